### design/neuron_mac_activation_defines.svh
// ---------------------------------------------------------------------------
// Neuron MAC and activation: assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef NEURON_MAC_ACTIVATION_DEFINES_SVH
`define NEURON_MAC_ACTIVATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/nma_pkg.sv
// ---------------------------------------------------------------------------
// Neuron MAC and activation: package
// Activation codes, fixed constants and the sigmoid lookup table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nma_pkg;

	typedef enum logic [1:0] {
		ACT_SIGMOID  = 2'd0,
		ACT_RELU     = 2'd1,
		ACT_LEAKY    = 2'd2,
		ACT_IDENTITY = 2'd3
	} act_mode_t;

	localparam int MODE_W      = 2;
	localparam int SIG_ENTRIES = 256;
	localparam int SIG_IDX_W   = 8;
	localparam int SIG_FRAC    = 16;
	localparam int LEAKY_MUL   = 655;
	localparam int LEAKY_SHIFT = 16;
	localparam logic [63:0] EXP_STEP = 64'd4162825045;

	typedef logic [SIG_ENTRIES-1:0][SIG_FRAC-1:0] sig_rom_t;

	// Sigmoid at the bin centres (2i - 255)/32 in Q0.16, rounded to nearest.
	// The exponential runs as a recurrence in Q0.32; the quotient is formed
	// by restoring division so that the table is settled at elaboration.
	function automatic sig_rom_t build_sig_rom();
		sig_rom_t    rom;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] quo;
		logic [63:0] rem;
		int          k;
		int          b;
		rom = '0;
		e = EXP_STEP;
		for (k = 0; k < SIG_ENTRIES / 2; k++) begin
			den = (64'd1 << 32) + e;
			num = (64'd1 << 48) + (den >> 1);
			quo = '0;
			rem = '0;
			for (b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= den) begin
					rem    = rem - den;
					quo[b] = 1'b1;
				end
			end
			rom[SIG_ENTRIES / 2 + k]     = quo[SIG_FRAC-1:0];
			rom[SIG_ENTRIES / 2 - 1 - k] = SIG_FRAC'((64'd1 << SIG_FRAC) - quo);
			e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
			e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
		end
		return rom;
	endfunction

	localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

### design/neuron_mac_activation.sv
// ---------------------------------------------------------------------------
// Neuron MAC and activation
// Multiply-accumulate over one node's weight and source pairs, then the
// configured activation on the node potential.
// ---------------------------------------------------------------------------
// Usage. Input transfers on the s_ channel carry weight, source value and
// bias in s_tdata; s_tuser flags the first pair of a node (the bias loads the
// accumulator) and s_tlast flags the final pair. Each node gives exactly one
// result transfer on the m_ channel: the activated value in m_tdata and, in
// m_tuser, a flag set when any clip happened during that node.
// The cfg_ channel writes the activation mode; it is always ready and should
// only be written while no node is in flight.
// Throughput is one input transfer per cycle unless a final pair waits for
// stage 3. A result passes the input, product, sum and output registers. The
// saturating accumulate bounds the rate; its loop closes through acc_q.
// Reset clears the pipeline valids, the accumulator, the clip flag and sets
// the mode to sigmoid. When the receiver stalls, the result is held in the
// output register; the stages behind it keep taking pairs into bubbles, and
// pairs that end no node are summed even while an earlier result waits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module neuron_mac_activation #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12,
	parameter int ACC_WIDTH  = 40
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Input stream. s_tdata, from bit 0: weight, source_value, bias.
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
	input  logic                                     s_tuser,   // first
	input  logic                                     s_tlast,   // last
	// Result stream. m_tdata, from bit 0: activation.
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_tdata,
	output logic                                     m_tuser,   // saturated
	// Configuration write: activation mode.
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [nma_pkg::MODE_W-1:0]               cfg_data
);

	import nma_pkg::*;

	localparam int DW    = DATA_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int AW    = ACC_WIDTH;
	localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;
	// Product and scaled bias are clamped to the accumulator range in a
	// width that holds both the raw value and the accumulator.
	localparam int PMW   = (2 * DW > AW) ? 2 * DW : AW;
	localparam int BMW   = (DW + FB > AW) ? DW + FB : AW;
	// Potential width and the common width of the activation arithmetic.
	localparam int PW    = AW - FB;
	localparam int CW0   = (PW > FB + 6) ? PW : FB + 6;
	localparam int CW1   = (CW0 > DW + 1) ? CW0 : DW + 1;
	localparam int CW    = (CW1 > 25) ? CW1 : 25;
	localparam int SIG_LSH = (FB >= SIG_FRAC) ? FB - SIG_FRAC : 0;
	localparam int SIG_RSH = (FB >= SIG_FRAC) ? 0 : SIG_FRAC - FB;
	localparam bit LK_CLAMP = (PW > 53);

	localparam logic signed [PMW-1:0] PROD_HI = {{(PMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [PMW-1:0] PROD_LO = ~PROD_HI;
	localparam logic signed [BMW-1:0] BIAS_HI = {{(BMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [BMW-1:0] BIAS_LO = ~BIAS_HI;
	localparam logic signed [AW-1:0]  ACC_HI  = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0]  ACC_LO  = ~ACC_HI;
	localparam logic signed [CW-1:0]  D_HI    = {{(CW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [CW-1:0]  D_LO    = ~D_HI;
	localparam logic signed [CW-1:0]  SIG_HI  = CW'((64'd8 << FB) - 64'd1);
	localparam logic signed [CW-1:0]  SIG_LO  = ~SIG_HI;
	localparam logic signed [CW-1:0]  LK_FLOOR = ~CW'((65'd1 << 52) - 65'd1);

	// Stage 1: input register.
	logic                    vld_s1;
	logic signed [DW-1:0]    weight_s1;
	logic signed [DW-1:0]    source_s1;
	logic signed [DW-1:0]    bias_s1;
	logic                    first_s1;
	logic                    last_s1;

	// Stage 2: clamped product and scaled bias.
	logic                    vld_s2;
	logic signed [AW-1:0]    prod_s2;
	logic                    pclip_s2;
	logic signed [AW-1:0]    bias_s2;
	logic                    bclip_s2;
	logic                    first_s2;
	logic                    last_s2;

	// Stage 3: finished node sum.
	logic                    vld_s3;
	logic signed [AW-1:0]    sum_s3;
	logic                    clip_s3;

	// Stage 4: output register.
	logic                    vld_s4;
	logic signed [DW-1:0]    act_s4;
	logic                    sat_s4;

	// Accumulator state and configuration.
	logic signed [AW-1:0]    acc_q;
	logic                    clip_q;
	act_mode_t               mode_q;

	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic rdy4;
	logic take2;

	// Each stage may load when it is empty or its content moves on. Pairs
	// that end no node never occupy stage 3, so they pass a waiting result.
	assign rdy4  = !vld_s4 || m_tready;
	assign rdy3  = !vld_s3 || rdy4;
	assign rdy2  = !vld_s2 || !last_s2 || rdy3;
	assign rdy1  = !vld_s1 || rdy2;
	assign take2 = vld_s2 && (!last_s2 || rdy3);

	assign s_tready  = rdy1;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_s4;
	assign m_tdata   = OUT_W'($unsigned(act_s4));
	assign m_tuser   = sat_s4;

	// ---- stage 2 logic: multiply and clamp -------------------------------
	logic signed [2*DW-1:0] prod_c;
	logic signed [PMW-1:0]  prod_x;
	logic signed [PMW-1:0]  prod_sat;
	logic                   prod_clip;
	logic signed [BMW-1:0]  bias_x;
	logic signed [BMW-1:0]  bias_sat;
	logic                   bias_clip;

	always_comb begin
		prod_c    = weight_s1 * source_s1;
		prod_x    = PMW'(prod_c);
		prod_clip = 1'b1;
		if (prod_x > PROD_HI) begin
			prod_sat = PROD_HI;
		end else if (prod_x < PROD_LO) begin
			prod_sat = PROD_LO;
		end else begin
			prod_sat  = prod_x;
			prod_clip = 1'b0;
		end
		bias_x    = BMW'(bias_s1) <<< FB;
		bias_clip = 1'b1;
		if (bias_x > BIAS_HI) begin
			bias_sat = BIAS_HI;
		end else if (bias_x < BIAS_LO) begin
			bias_sat = BIAS_LO;
		end else begin
			bias_sat  = bias_x;
			bias_clip = 1'b0;
		end
	end

	// ---- stage 3 logic: saturating accumulate ----------------------------
	logic signed [AW-1:0] acc_base;
	logic                 base_clip;
	logic signed [AW:0]   acc_sum;
	logic                 add_ovf;
	logic signed [AW-1:0] acc_next;
	logic                 clip_next;

	always_comb begin
		acc_base  = first_s2 ? bias_s2 : acc_q;
		base_clip = first_s2 ? bclip_s2 : clip_q;
		acc_sum   = {acc_base[AW-1], acc_base} + {prod_s2[AW-1], prod_s2};
		add_ovf   = acc_sum[AW] ^ acc_sum[AW-1];
		if (add_ovf) begin
			acc_next = acc_sum[AW] ? ACC_LO : ACC_HI;
		end else begin
			acc_next = acc_sum[AW-1:0];
		end
		clip_next = base_clip | pclip_s2 | add_ovf;
	end

	// ---- stage 4 logic: activation and output clamp ----------------------
	// The potential is the node sum shifted right by FB, toward minus
	// infinity, which is simply its upper bits.
	logic signed [PW-1:0]   pot;
	logic signed [CW-1:0]   pw;
	logic signed [CW-1:0]   sig_in;
	logic signed [CW-1:0]   sig_off;
	logic [SIG_IDX_W-1:0]   sig_idx;
	logic signed [CW-1:0]   sig_val;
	logic signed [CW-1:0]   lk_in;
	logic signed [CW+10:0]  lk_prod;
	logic signed [CW+10:0]  lk_shift;
	logic signed [CW-1:0]   act_val;
	logic signed [CW-1:0]   act_sat;
	logic                   out_clip;

	always_comb begin
		pot = $signed(sum_s3[AW-1:FB]);
		pw  = CW'(pot);

		if (pw > SIG_HI) begin
			sig_in = SIG_HI;
		end else if (pw < SIG_LO) begin
			sig_in = SIG_LO;
		end else begin
			sig_in = pw;
		end
		sig_off = sig_in - SIG_LO;
		sig_idx = sig_off[FB+3:FB-4];
		sig_val = $signed((CW'(SIG_ROM[sig_idx]) << SIG_LSH) >> SIG_RSH);

		lk_in = (LK_CLAMP && (pw < LK_FLOOR)) ? LK_FLOOR : pw;
		lk_prod  = (CW+11)'(lk_in) * (CW+11)'(LEAKY_MUL);
		lk_shift = lk_prod >>> LEAKY_SHIFT;

		case (mode_q)
			ACT_SIGMOID: begin
				act_val = sig_val;
			end
			ACT_RELU: begin
				act_val = pw[CW-1] ? '0 : pw;
			end
			ACT_LEAKY: begin
				act_val = pw[CW-1] ? CW'(lk_shift) : pw;
			end
			default: begin
				act_val = pw;
			end
		endcase

		out_clip = 1'b1;
		if (act_val > D_HI) begin
			act_sat = D_HI;
		end else if (act_val < D_LO) begin
			act_sat = D_LO;
		end else begin
			act_sat  = act_val;
			out_clip = 1'b0;
		end
	end

	// ---- control registers -----------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			acc_q  <= '0;
			clip_q <= 1'b0;
			mode_q <= ACT_SIGMOID;
		end else begin
			if (rdy1) begin
				vld_s1 <= s_tvalid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= take2 && last_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
			// A node's final pair hands its sum on and leaves the
			// accumulator clear for the next node.
			if (take2) begin
				if (last_s2) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
				end else begin
					acc_q  <= acc_next;
					clip_q <= clip_next;
				end
			end
			if (cfg_valid && cfg_ready) begin
				mode_q <= act_mode_t'(cfg_data);
			end
		end
	end

	// ---- payload registers -----------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			weight_s1 <= $signed(s_tdata[DW-1:0]);
			source_s1 <= $signed(s_tdata[2*DW-1:DW]);
			bias_s1   <= $signed(s_tdata[3*DW-1:2*DW]);
			first_s1  <= s_tuser;
			last_s1   <= s_tlast;
		end
		if (rdy2 && vld_s1) begin
			prod_s2  <= AW'(prod_sat);
			pclip_s2 <= prod_clip;
			bias_s2  <= AW'(bias_sat);
			bclip_s2 <= bias_clip;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
		if (take2 && last_s2) begin
			sum_s3  <= acc_next;
			clip_s3 <= clip_next;
		end
		if (rdy4 && vld_s3) begin
			act_s4 <= DW'(act_sat);
			sat_s4 <= clip_s3 | out_clip;
		end
	end

	// ---- assertions -------------------------------------------------------
`include "neuron_mac_activation_defines.svh"

	`NMA_ASSERT_NEXT(a_acc_clear_after_last, take2 && last_s2, (acc_q == '0) && !clip_q, "accumulator not cleared after the final pair of a node")
	`NMA_ASSERT_NEXT(a_s3_holds_on_stall, vld_s3 && !rdy4, vld_s3 && $stable(sum_s3) && $stable(clip_s3), "waiting node sum lost or changed")
	`NMA_ASSERT_NEXT(a_s2_last_holds, vld_s2 && last_s2 && !rdy3, vld_s2 && last_s2 && $stable(prod_s2), "final pair left stage 2 while stage 3 was full")
	`NMA_ASSERT_SAME(a_ready_when_empty, !vld_s1, s_tready, "input not ready with an empty input register")

endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// Neuron MAC and activation: self-checking bench
// Streams weight and source pairs grouped into nodes through the block under
// every activation mode, predicts each node result in a scoreboard and checks
// every result transfer field by field, with random gaps and stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import nma_pkg::*;

	localparam int     DATA_W      = 16;
	localparam int     FRAC        = 12;
	localparam longint ACC_MAX     = (64'sd1 <<< 39) - 1;
	localparam longint ACC_MIN     = -ACC_MAX - 1;
	localparam longint OUT_MAX     = 32767;
	localparam longint OUT_MIN     = -32768;
	localparam longint SIG_LO      = -(64'sd8 <<< FRAC);
	localparam longint SIG_HI      = (64'sd8 <<< FRAC) - 1;
	localparam longint LEAKY_FLOOR = -(64'sd1 <<< 52);
	localparam int     ITEM_TARGET = 2000;
	// The settle time leaves ample room for pairs still in the pipe before a
	// mode write or the end.
	localparam int     SETTLE      = 8;
	// The longest legal quiet stretch is a random gap or stall plus the settle
	// time, far below this limit, so the limit only trips on a real hang.
	localparam int     IDLE_LIMIT  = 2000;

	// One weight and source pair, with the node flags.
	typedef struct {
		logic signed [DATA_W-1:0] weight;
		logic signed [DATA_W-1:0] source_value;
		logic signed [DATA_W-1:0] bias;
		logic                     first;
		logic                     last;
	} mac_pair_t;

	// One node result.
	typedef struct {
		logic signed [DATA_W-1:0] activation;
		logic                     saturated;
	} node_out_t;

	// Predicts node results from the accepted pairs and checks the result
	// transfers against them in order.
	class neuron_scoreboard;
		act_mode_t   mode;
		longint      acc;
		bit          clip_seen;
		logic [15:0] sig_table [SIG_ENTRIES];
		node_out_t   expected_q [$];
		int          failures;
		int          results_checked;
		int          clipped_results;
		bit [3:0]    modes_seen;

		function new();
			longint unsigned e;
			longint unsigned den;
			longint unsigned s;
			mode            = ACT_SIGMOID;
			acc             = 0;
			clip_seen       = 1'b0;
			failures        = 0;
			results_checked = 0;
			clipped_results = 0;
			modes_seen      = '0;
			// Sigmoid at the bin centres, upper half from the exponential
			// recurrence and the lower half mirrored about one half.
			e = EXP_STEP;
			for (int k = 0; k < SIG_ENTRIES / 2; k++) begin
				den = (64'd1 << 32) + e;
				s   = ((64'd1 << 48) + den / 2) / den;
				sig_table[SIG_ENTRIES / 2 + k]     = 16'(s);
				sig_table[SIG_ENTRIES / 2 - 1 - k] = 16'(64'd65536 - s);
				e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
				e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
			end
		endfunction

		function longint clip_to(longint x, longint lo, longint hi, inout bit flag);
			if (x > hi) begin
				flag = 1'b1;
				return hi;
			end
			if (x < lo) begin
				flag = 1'b1;
				return lo;
			end
			return x;
		endfunction

		function void set_mode(act_mode_t m);
			mode = m;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void note_input(mac_pair_t p);
			longint    prod;
			longint    pot;
			longint    act;
			bit        out_clip;
			bit        unused_flag;
			node_out_t r;
			if (p.first) begin
				clip_seen = 1'b0;
				acc = clip_to(longint'(p.bias) * (64'sd1 <<< FRAC), ACC_MIN, ACC_MAX,
					clip_seen);
			end
			prod = clip_to(longint'(p.weight) * longint'(p.source_value), ACC_MIN, ACC_MAX,
				clip_seen);
			if (prod > 0 && acc > ACC_MAX - prod) begin
				acc       = ACC_MAX;
				clip_seen = 1'b1;
			end else if (prod < 0 && acc < ACC_MIN - prod) begin
				acc       = ACC_MIN;
				clip_seen = 1'b1;
			end else begin
				acc = acc + prod;
			end
			if (!p.last)
				return;

			// Potential back at the operand scaling, rounded down.
			pot = acc >>> FRAC;
			case (mode)
				ACT_SIGMOID: begin
					unused_flag = 1'b0;
					pot = clip_to(pot, SIG_LO, SIG_HI, unused_flag);
					act = longint'(sig_table[(pot - SIG_LO) >> (FRAC - 4)] >> (SIG_FRAC - FRAC));
				end
				ACT_RELU: begin
					act = (pot < 0) ? 0 : pot;
				end
				ACT_LEAKY: begin
					if (pot >= 0) begin
						act = pot;
					end else begin
						if (pot < LEAKY_FLOOR)
							pot = LEAKY_FLOOR;
						act = (pot * LEAKY_MUL) >>> LEAKY_SHIFT;
					end
				end
				default: begin
					act = pot;
				end
			endcase
			out_clip = clip_seen;
			act = clip_to(act, OUT_MIN, OUT_MAX, out_clip);
			r.activation = DATA_W'(act);
			r.saturated  = out_clip;
			expected_q.insert(expected_q.size(), r);
			modes_seen[mode] = 1'b1;
			acc       = 0;
			clip_seen = 1'b0;
		endfunction

		function void check_result(logic signed [DATA_W-1:0] act, logic sat);
			node_out_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with no node outstanding: activation %0d, saturated %0b",
					act, sat);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (sat === 1'b1)
				clipped_results++;
			if (act !== want.activation) begin
				$error("activation: expected %0d, got %0d", want.activation, act);
				failures++;
			end
			if (sat !== want.saturated) begin
				$error("saturated: expected %0b, got %0b", want.saturated, sat);
				failures++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [47:0]       s_tdata;   // weight, source_value, bias from bit 0
	logic              s_tuser;   // first
	logic              s_tlast;   // last
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // activation
	logic              m_tuser;   // saturated
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MODE_W-1:0] cfg_data;

	neuron_scoreboard book = new();

	mac_pair_t stim_q [$];
	int        items_queued;
	int        pairs_sent;
	int        sat_nodes;
	int        idle_cycles;
	bit        gap_on;
	bit        stall_on;

	neuron_mac_activation u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Operand values: the extremes, values within two of zero, and the full range.
	function automatic logic signed [DATA_W-1:0] draw_q412();
		case ($urandom_range(0, 9))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			2, 3:    return DATA_W'($urandom_range(0, 16383)) - 16'sd8192;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Appends one pair to the stimulus queue.
	function automatic void queue_pair(mac_pair_t p);
		stim_q.insert(stim_q.size(), p);
	endfunction

	function automatic void add_node(int len);
		mac_pair_t p;
		for (int i = 0; i < len; i++) begin
			p.weight       = draw_q412();
			p.source_value = draw_q412();
			p.bias         = draw_q412();
			p.first        = (i == 0);
			p.last         = (i == len - 1);
			queue_pair(p);
		end
	endfunction

	// A stray pair with random flags: a node without its opening pair, a
	// restart mid-node, an extra pair on the running sum, or a one-pair node.
	function automatic void add_stray();
		mac_pair_t p;
		p.weight       = draw_q412();
		p.source_value = draw_q412();
		p.bias         = draw_q412();
		p.first        = 1'($urandom_range(0, 1));
		p.last         = 1'($urandom_range(0, 1));
		queue_pair(p);
	endfunction

	// A long node of extreme products of one sign that drives the accumulator
	// into its limit, followed by a few random pairs that pull it back.
	function automatic void add_saturating_node(bit upward);
		mac_pair_t p;
		for (int i = 0; i < 526; i++) begin
			if (i < 520) begin
				p.weight       = upward ? 16'sh8000 : 16'sh7fff;
				p.source_value = 16'sh8000;
			end else begin
				p.weight       = draw_q412();
				p.source_value = draw_q412();
			end
			p.bias  = upward ? 16'sh7fff : 16'sh8000;
			p.first = (i == 0);
			p.last  = (i == 525);
			queue_pair(p);
		end
		sat_nodes++;
	endfunction

	// Fixed opening set, run once per mode: a pair ending a node on the
	// cleared accumulator, one-pair nodes at the positive and negative
	// extremes, and a three-pair node whose bias is ignored after the first.
	function automatic void add_directed();
		mac_pair_t set [6];
		set[0] = '{16'sd4096,  16'sd4096,  16'sd0,     1'b0, 1'b1};
		set[1] = '{16'sh8000,  16'sh8000,  16'sh7fff,  1'b1, 1'b1};
		set[2] = '{16'sh7fff,  16'sh8000,  16'sh8000,  1'b1, 1'b1};
		set[3] = '{16'sd2048,  -16'sd4096, 16'sh8000,  1'b1, 1'b0};
		set[4] = '{-16'sd1,    16'sd1,     16'sh7fff,  1'b0, 1'b0};
		set[5] = '{16'sh7fff,  16'sd1,     16'sd0,     1'b0, 1'b1};
		foreach (set[i])
			queue_pair(set[i]);
	endfunction

	// Sends the queued pairs in bursts of random length. Between bursts the
	// valid drops for a random gap while the data lines carry noise.
	task automatic push_pairs();
		mac_pair_t p;
		int        burst_left;
		int        gap;
		burst_left = $urandom_range(1, 24);
		while (stim_q.size() != 0) begin
			p = stim_q.pop_front();
			@(negedge clk);
			s_tvalid = 1'b1;
			s_tdata  = {p.bias, p.source_value, p.weight};
			s_tuser  = p.first;
			s_tlast  = p.last;
			do @(posedge clk); while (!s_tready);
			book.note_input(p);
			pairs_sent++;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = gap_on ? $urandom_range(0, 6) : 0;
				if (gap > 0) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					s_tdata  = 48'({$urandom, $urandom});
					s_tuser  = 1'($urandom_range(0, 1));
					s_tlast  = 1'($urandom_range(0, 1));
					repeat (gap - 1) @(negedge clk);
				end
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_mode(act_mode_t m);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = m;
		do @(posedge clk); while (!cfg_ready);
		book.set_mode(m);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Waits for every outstanding node result, then lets the pipeline settle.
	task automatic wait_idle();
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Receiver: ready for a random run, then, when stalls are on, stalled for a
	// random run, in a rhythm that has nothing to do with the sender's bursts.
	initial begin
		int run;
		m_tready = 1'b0;
		forever begin
			run = $urandom_range(1, 12);
			repeat (run) begin
				@(negedge clk);
				m_tready = 1'b1;
			end
			if (stall_on) begin
				run = $urandom_range(1, 8);
				repeat (run) begin
					@(negedge clk);
					m_tready = 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.check_result(m_tdata, m_tuser);
	end

	// Watchdog on cycles without any transfer on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		act_mode_t mode_order [4];
		act_mode_t m;
		int        phase;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		s_tlast      = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		items_queued = 0;
		pairs_sent   = 0;
		sat_nodes    = 0;
		gap_on       = 1'b1;
		stall_on     = 1'b1;
		arst_n       = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed set under each mode, identity and sigmoid as the extremes.
		mode_order = '{ACT_IDENTITY, ACT_RELU, ACT_LEAKY, ACT_SIGMOID};
		foreach (mode_order[i]) begin
			write_mode(mode_order[i]);
			add_directed();
			items_queued += stim_q.size();
			push_pairs();
			wait_idle();
		end

		// Random phases. Each phase has its own mode, gap and stall settings
		// and closes with a complete node so that the mode can change safely.
		phase = 0;
		while (items_queued < ITEM_TARGET) begin
			m        = act_mode_t'($urandom_range(0, 3));
			gap_on   = ($urandom_range(0, 3) != 0);
			stall_on = ($urandom_range(0, 3) != 0);
			write_mode(m);
			if (phase == 2 || phase == 7)
				add_saturating_node(phase == 2);
			while (stim_q.size() < 120) begin
				if ($urandom_range(0, 9) == 0)
					add_stray();
				else if ($urandom_range(0, 7) == 0)
					add_node($urandom_range(9, 40));
				else
					add_node($urandom_range(1, 8));
			end
			add_node($urandom_range(1, 4));
			items_queued += stim_q.size();
			push_pairs();
			wait_idle();
			phase++;
		end

		wait_idle();
		$display("Sent %0d pairs in %0d random phases; %0d node results checked, %0d clipped.",
			pairs_sent, phase, book.results_checked, book.clipped_results);
		$display("Activation modes with results: %b; accumulator saturation nodes: %0d.",
			book.modes_seen, sat_nodes);
		if (book.failures == 0 && book.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### files.f
+incdir+design
design/nma_pkg.sv
design/neuron_mac_activation.sv
bench/testbench.sv
